[src/bslt_pkg.sv]
// Package for the battery status and level tracker: codes, register map,
// payload and configuration structs, and the voltage-to-level table.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package bslt_pkg;

  // Field widths
  localparam int FUNC_W    = 2;
  localparam int CODE_W    = 7;
  localparam int CHG_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int LEVEL_W   = 8;
  localparam int MV_W      = 13;
  localparam int POLL_W    = 4;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;
  localparam int VBAT_CODES = 1 << CODE_W;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_STATUS = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LEVEL  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESEED = 2'd2;

  // Charger states
  localparam logic [CHG_W-1:0] CHG_NONE = 2'd0;
  localparam logic [CHG_W-1:0] CHG_PRE  = 2'd1;
  localparam logic [CHG_W-1:0] CHG_FAST = 2'd2;
  localparam logic [CHG_W-1:0] CHG_DONE = 2'd3;

  // Reported status
  localparam logic [STATUS_W-1:0] ST_UNKNOWN     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_BATT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CHARGING    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CHARGED     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DISCHARGING = 3'd4;

  // Register indexes (byte address is four times the index)
  localparam logic [2:0] REG_ENABLE         = 3'd0;
  localparam logic [2:0] REG_BATT_FLOOR_MV  = 3'd1;
  localparam logic [2:0] REG_MIN_CHARGE_MA  = 3'd2;
  localparam logic [2:0] REG_RAMP_POLLS     = 3'd3;
  localparam logic [2:0] REG_DEBOUNCE_READS = 3'd4;

  // Register reset values
  localparam logic [MV_W-1:0]   BATT_FLOOR_MV_RST  = 13'd3000;
  localparam logic [MV_W-1:0]   MIN_CHARGE_MA_RST  = 13'd50;
  localparam logic [POLL_W-1:0] RAMP_POLLS_RST     = 4'd5;
  localparam logic [POLL_W-1:0] DEBOUNCE_READS_RST = 4'd3;

  // Conversion constants
  localparam int MV_BASE       = 2304;
  localparam int MV_STEP       = 20;
  localparam int MA_STEP       = 50;
  localparam int LEVEL_MIN_MV  = 3270;
  localparam int LEVEL_MAX_MV  = 4200;
  localparam int LEVEL_SPAN_MV = LEVEL_MAX_MV - LEVEL_MIN_MV;
  localparam int LEVEL_FULL    = 100;

  localparam logic signed [LEVEL_W-1:0] LEVEL_NONE = -8'sd1;
  localparam logic [POLL_W-1:0]         COUNT_MAX  = '1;

  typedef struct packed {
    logic              enable;
    logic [MV_W-1:0]   batt_floor_mv;
    logic [MV_W-1:0]   min_charge_ma;
    logic [POLL_W-1:0] ramp_polls;
    logic [POLL_W-1:0] debounce_reads;
  } cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CODE_W-1:0] vbat_code;
    logic [CHG_W-1:0]  charge_state;
    logic [CODE_W-1:0] current_code;
  } meas_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [LEVEL_W-1:0] level;
    logic [MV_W-1:0]           voltage_mv;
  } report_t;

  typedef logic [CODE_W-1:0] level_lut_t [VBAT_CODES];

  // Percent level for each voltage code, worked out at elaboration.
  function automatic level_lut_t build_level_lut();
    level_lut_t lut;
    int         mv;
    int         pct;
    for (int c = 0; c < VBAT_CODES; c++) begin
      mv = (c == 0) ? 0 : c * MV_STEP + MV_BASE;
      if (mv <= LEVEL_MIN_MV) begin
        pct = 0;
      end else begin
        pct = (mv - LEVEL_MIN_MV) * LEVEL_FULL / LEVEL_SPAN_MV;
        if (pct > LEVEL_FULL) begin
          pct = LEVEL_FULL;
        end
      end
      lut[c] = CODE_W'(pct);
    end
    return lut;
  endfunction

  localparam level_lut_t LEVEL_LUT = build_level_lut();

endpackage

[src/bslt_if.sv]
// Handshake channels of the battery status and level tracker: the
// measurement channel and the report channel. Depends on bslt_pkg.
`timescale 1ns / 1ps

interface bslt_meas_if import bslt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CODE_W-1:0] vbat_code;
  logic [CHG_W-1:0]  charge_state;
  logic [CODE_W-1:0] current_code;

  modport source (output valid, func, vbat_code, charge_state, current_code, input ready);
  modport sink (input valid, func, vbat_code, charge_state, current_code, output ready);
endinterface

interface bslt_report_if import bslt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [LEVEL_W-1:0] level;
  logic [MV_W-1:0]           voltage_mv;

  modport source (output valid, status, level, voltage_mv, input ready);
  modport sink (input valid, status, level, voltage_mv, output ready);
endinterface

[src/bslt_core.sv]
// Tracker core: decodes one registered measurement, classifies the battery,
// and holds the level and debounce state. Depends on bslt_pkg.
`timescale 1ns / 1ps

module bslt_core import bslt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    fire,
  input  meas_t   meas,
  output report_t report
);

  logic signed [LEVEL_W-1:0] last_level, last_level_next;
  logic [POLL_W-1:0]         ramp_count, ramp_count_next;
  logic                      was_charging, was_charging_next;
  logic [POLL_W-1:0]         low_count, low_count_next;

  logic [MV_W-1:0]     mv;
  logic [MV_W-1:0]     ma;
  logic                above_floor;
  logic [CODE_W-1:0]   map_level;
  logic [POLL_W-1:0]   low_count_inc;
  logic [STATUS_W-1:0] cls_status;
  logic [POLL_W-1:0]   cls_low_count;
  logic                charging;
  logic [POLL_W-1:0]   ramp_base;
  logic [POLL_W-1:0]   ramp_inc;
  logic                rising;

  // Decode voltage and current; the level comes from the constant table.
  always_comb begin
    mv = (meas.vbat_code == '0) ? '0
       : MV_W'(MV_BASE) + MV_W'(meas.vbat_code) * MV_W'(MV_STEP);
    ma          = MV_W'(meas.current_code) * MV_W'(MA_STEP);
    above_floor = (mv >= cfg.batt_floor_mv);
    map_level   = LEVEL_LUT[meas.vbat_code];
  end

  // Classification with the saturating low-current debounce.
  always_comb begin
    low_count_inc = (low_count == COUNT_MAX) ? low_count : low_count + 1'b1;
    cls_low_count = low_count;
    cls_status    = ST_DISCHARGING;
    if (!above_floor) begin
      cls_status = ST_NO_BATT;
    end else begin
      case (meas.charge_state)
        CHG_PRE, CHG_FAST: begin
          if (ma < cfg.min_charge_ma) begin
            cls_low_count = low_count_inc;
            cls_status    = (low_count_inc >= cfg.debounce_reads) ? ST_NO_BATT : ST_CHARGING;
          end else begin
            cls_low_count = '0;
            cls_status    = ST_CHARGING;
          end
        end
        CHG_DONE: cls_status = ST_CHARGED;
        default:  cls_status = ST_DISCHARGING;
      endcase
    end
  end

  // Rate-limit terms for the level update.
  always_comb begin
    charging  = (cls_status == ST_CHARGING) || (cls_status == ST_CHARGED);
    ramp_base = (was_charging && !charging) ? '0 : ramp_count;
    ramp_inc  = ramp_base + 1'b1;
    rising    = !last_level[LEVEL_W-1] && (LEVEL_W'(map_level) > LEVEL_W'(last_level));
  end

  // Operation select: report fields and next state.
  always_comb begin
    report.status     = ST_UNKNOWN;
    report.level      = LEVEL_NONE;
    report.voltage_mv = cfg.enable ? mv : '0;
    last_level_next   = last_level;
    ramp_count_next   = ramp_count;
    was_charging_next = was_charging;
    low_count_next    = low_count;
    if (cfg.enable) begin
      unique case (meas.func)
        FUNC_STATUS: begin
          report.status  = cls_status;
          low_count_next = cls_low_count;
        end
        FUNC_LEVEL: begin
          report.status  = cls_status;
          low_count_next = cls_low_count;
          if (cls_status == ST_NO_BATT) begin
            was_charging_next = 1'b0;
          end else begin
            was_charging_next = charging;
            if (rising) begin
              if (!charging) begin
                ramp_count_next = ramp_base;
                last_level_next = last_level;
              end else if (ramp_inc >= cfg.ramp_polls) begin
                ramp_count_next = '0;
                last_level_next = last_level + 8'sd1;
              end else begin
                ramp_count_next = ramp_inc;
                last_level_next = last_level;
              end
            end else begin
              ramp_count_next = '0;
              last_level_next = LEVEL_W'(map_level);
            end
            report.level = last_level_next;
          end
        end
        FUNC_RESEED: begin
          if (above_floor) begin
            last_level_next = LEVEL_W'(map_level);
          end
          ramp_count_next   = '0;
          was_charging_next = 1'b0;
          report.level      = last_level_next;
        end
        default: begin
          report.level = LEVEL_NONE;
        end
      endcase
    end
  end

  // Tracker state, updated once per measurement leaving the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level   <= LEVEL_NONE;
      ramp_count   <= '0;
      was_charging <= 1'b0;
      low_count    <= '0;
    end else if (fire) begin
      last_level   <= last_level_next;
      ramp_count   <= ramp_count_next;
      was_charging <= was_charging_next;
      low_count    <= low_count_next;
    end
  end

endmodule

[src/battery_status_level_tracker.sv]
// Battery status and level tracker. A measurement transaction on meas
// carries an operation, a voltage code, a charger state and a current code;
// each one produces exactly one report transaction with status, percent level
// and decoded millivolts. The block takes one measurement every clock cycle
// while the report channel is not stalled; a report passes through the input
// register and then the report register, with the tracker state updated as the
// measurement leaves the input register. Configuration
// registers sit on the APB port at byte addresses 0x00 enable, 0x04 no-battery
// floor (mV), 0x08 minimum charge current (mA), 0x0C polls per upward step and
// 0x10 debounce reads; write them while idle.
// Depends on bslt_pkg, bslt_if and bslt_core.
`timescale 1ns / 1ps

module battery_status_level_tracker import bslt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  bslt_meas_if.sink          meas,
  bslt_report_if.source      report
);

  cfg_t       cfg;
  logic [2:0] reg_index;
  logic       cfg_write;

  logic       stage_valid;
  meas_t      stage_meas;
  logic       stage_fire;
  report_t    core_report;
  logic       report_valid;
  report_t    report_data;

  // Configuration registers
  assign pready    = 1'b1;
  assign reg_index = paddr[APB_AW-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable         <= 1'b0;
      cfg.batt_floor_mv  <= BATT_FLOOR_MV_RST;
      cfg.min_charge_ma  <= MIN_CHARGE_MA_RST;
      cfg.ramp_polls     <= RAMP_POLLS_RST;
      cfg.debounce_reads <= DEBOUNCE_READS_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_ENABLE:         cfg.enable         <= pwdata[0];
        REG_BATT_FLOOR_MV:  cfg.batt_floor_mv  <= pwdata[MV_W-1:0];
        REG_MIN_CHARGE_MA:  cfg.min_charge_ma  <= pwdata[MV_W-1:0];
        REG_RAMP_POLLS:     cfg.ramp_polls     <= pwdata[POLL_W-1:0];
        REG_DEBOUNCE_READS: cfg.debounce_reads <= pwdata[POLL_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_index)
      REG_ENABLE:         prdata = APB_DW'(cfg.enable);
      REG_BATT_FLOOR_MV:  prdata = APB_DW'(cfg.batt_floor_mv);
      REG_MIN_CHARGE_MA:  prdata = APB_DW'(cfg.min_charge_ma);
      REG_RAMP_POLLS:     prdata = APB_DW'(cfg.ramp_polls);
      REG_DEBOUNCE_READS: prdata = APB_DW'(cfg.debounce_reads);
      default:            prdata = '0;
    endcase
  end

  // Input register: moves on whenever the report register can take its result.
  assign stage_fire = stage_valid && (!report_valid || report.ready);
  assign meas.ready = !stage_valid || stage_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (meas.ready) begin
      stage_valid <= meas.valid;
    end
    if (meas.valid && meas.ready) begin
      stage_meas.func         <= meas.func;
      stage_meas.vbat_code    <= meas.vbat_code;
      stage_meas.charge_state <= meas.charge_state;
      stage_meas.current_code <= meas.current_code;
    end
  end

  bslt_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (stage_fire),
    .meas   (stage_meas),
    .report (core_report)
  );

  // Report register
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (stage_fire) begin
      report_valid <= 1'b1;
    end else if (report.ready) begin
      report_valid <= 1'b0;
    end
    if (stage_fire) begin
      report_data <= core_report;
    end
  end

  assign report.valid      = report_valid;
  assign report.status     = report_data.status;
  assign report.level      = report_data.level;
  assign report.voltage_mv = report_data.voltage_mv;

endmodule
